@@ rtl/core/sdfs_pkg.sv @@
package sdfs_pkg;

    // Default word length shifted out per write
    localparam int WORD_BITS = 16;
    // Words buffered between request decode and the pin sequencer
    localparam int QUEUE_DEPTH = 2;

    // Full command word layout
    localparam int          CMD_W       = 16;
    localparam logic [11:0] SAMPLE_MASK = 12'hFFF;
    localparam logic [15:0] CMD_BIT     = 16'h4000;
    localparam logic [15:0] CHAN_A_BITS = 16'h2000;
    localparam logic [15:0] CHAN_B_BITS = 16'h3000;

    // Channel selection codes
    localparam logic [1:0] FUNC_BOTH = 2'd0;
    localparam logic [1:0] FUNC_A    = 2'd1;
    localparam logic [1:0] FUNC_B    = 2'd2;

    // Configuration register map
    localparam int         CFG_ADDR_W  = 3;
    localparam logic       REG_DELAY   = 1'b0;
    localparam logic       REG_HALF    = 1'b1;
    localparam logic [15:0] DELAY_RESET = 16'd84;
    localparam logic [7:0]  HALF_RESET  = 8'd16;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] data_value;
    } t_req;

    typedef struct packed {
        logic        cs_n;
        logic        sclk;
        logic        mosi;
        logic        ldac_n;
        logic [15:0] hold_ticks;
        logic        last;
    } t_seg;

    typedef struct packed {
        logic [15:0] delay_ticks;
        logic [7:0]  half_bit_ticks;
    } t_timing;

    typedef enum logic [3:0] {
        SEG_IDLE,
        SEG_CS_LO,
        SEG_CS_HI,
        SEG_SETUP,
        SEG_BIT_LO,
        SEG_BIT_HI,
        SEG_END_LO,
        SEG_END_HI,
        SEG_LOAD,
        SEG_DONE
    } t_seg_state;

endpackage

@@ rtl/core/sdfs_front.sv @@
module sdfs_front #(
    parameter int WORD_BITS = sdfs_pkg::WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  sdfs_pkg::t_req       i_in_data,
    output logic                 o_in_stall,
    output logic                 o_push,
    output logic [WORD_BITS-1:0] o_word,
    input  logic                 i_full
);

    logic                          r_vld;
    logic                          n_vld;
    logic [WORD_BITS-1:0]          r_word;
    logic [sdfs_pkg::CMD_W-1:0]    cmd;
    logic [sdfs_pkg::CMD_W-1:0]    chan;
    logic                          accept;

    // channel bits; unused selector adds none
    always_comb begin
        case (i_in_data.func)
            sdfs_pkg::FUNC_A: chan = sdfs_pkg::CHAN_A_BITS;
            sdfs_pkg::FUNC_B: chan = sdfs_pkg::CHAN_B_BITS;
            default:          chan = '0;
        endcase
        cmd = {4'b0, i_in_data.data_value & sdfs_pkg::SAMPLE_MASK} | chan | sdfs_pkg::CMD_BIT;
    end

    assign o_in_stall = r_vld && i_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_vld && !i_full;
    assign o_word     = r_word;
    assign n_vld      = accept || (r_vld && i_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= cmd[WORD_BITS-1:0];
        end
    end

endmodule

@@ rtl/core/sdfs_queue.sv @@
module sdfs_queue #(
    parameter int DEPTH = sdfs_pkg::QUEUE_DEPTH,
    parameter int WIDTH = sdfs_pkg::WORD_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + 1'b1;
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/core/sdfs_back.sv @@
module sdfs_back #(
    parameter int WORD_BITS = sdfs_pkg::WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdfs_pkg::t_timing    i_timing,
    input  logic                 i_q_valid,
    input  logic [WORD_BITS-1:0] i_q_word,
    output logic                 o_q_pop,
    output logic                 o_seg_valid,
    output sdfs_pkg::t_seg       o_seg,
    input  logic                 i_seg_stall
);

    localparam int CNT_W = $clog2(WORD_BITS);

    sdfs_pkg::t_seg_state r_state;
    sdfs_pkg::t_seg_state n_state;
    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic                 r_out_valid;
    logic                 n_out_valid;
    sdfs_pkg::t_seg       r_out;
    sdfs_pkg::t_seg       n_out;
    sdfs_pkg::t_seg       seg;
    logic                 adv;
    logic [15:0]          d_ticks;
    logic [15:0]          h_ticks;

    // zero timing values behave as one
    assign d_ticks = (i_timing.delay_ticks == '0) ? 16'd1 : i_timing.delay_ticks;
    assign h_ticks = (i_timing.half_bit_ticks == '0) ? 16'd1
                                                     : {8'b0, i_timing.half_bit_ticks};

    // output slot free this cycle
    assign adv = !r_out_valid || !i_seg_stall;

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_seg_stall;
        o_q_pop     = 1'b0;

        seg.cs_n       = 1'b0;
        seg.sclk       = 1'b1;
        seg.mosi       = 1'b0;
        seg.ldac_n     = 1'b1;
        seg.hold_ticks = d_ticks;
        seg.last       = 1'b0;

        case (r_state)
            sdfs_pkg::SEG_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_word  = i_q_word;
                    n_cnt   = CNT_W'(WORD_BITS - 1);
                    n_state = sdfs_pkg::SEG_CS_LO;
                end
            end
            sdfs_pkg::SEG_CS_LO: begin
                if (adv) begin
                    n_state = sdfs_pkg::SEG_CS_HI;
                end
            end
            sdfs_pkg::SEG_CS_HI: begin
                seg.cs_n = 1'b1;
                if (adv) begin
                    n_state = sdfs_pkg::SEG_SETUP;
                end
            end
            sdfs_pkg::SEG_SETUP: begin
                seg.hold_ticks = h_ticks;
                if (adv) begin
                    n_state = sdfs_pkg::SEG_BIT_LO;
                end
            end
            sdfs_pkg::SEG_BIT_LO: begin
                seg.sclk       = 1'b0;
                seg.mosi       = r_word[WORD_BITS-1];
                seg.hold_ticks = h_ticks;
                if (adv) begin
                    n_state = sdfs_pkg::SEG_BIT_HI;
                end
            end
            sdfs_pkg::SEG_BIT_HI: begin
                seg.mosi       = r_word[WORD_BITS-1];
                seg.hold_ticks = h_ticks;
                if (adv) begin
                    n_word = {r_word[WORD_BITS-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        n_state = sdfs_pkg::SEG_END_LO;
                    end else begin
                        n_cnt   = r_cnt - 1'b1;
                        n_state = sdfs_pkg::SEG_BIT_LO;
                    end
                end
            end
            sdfs_pkg::SEG_END_LO: begin
                if (adv) begin
                    n_state = sdfs_pkg::SEG_END_HI;
                end
            end
            sdfs_pkg::SEG_END_HI: begin
                seg.cs_n = 1'b1;
                if (adv) begin
                    n_state = sdfs_pkg::SEG_LOAD;
                end
            end
            sdfs_pkg::SEG_LOAD: begin
                seg.cs_n   = 1'b1;
                seg.ldac_n = 1'b0;
                if (adv) begin
                    n_state = sdfs_pkg::SEG_DONE;
                end
            end
            sdfs_pkg::SEG_DONE: begin
                seg.cs_n       = 1'b1;
                seg.hold_ticks = 16'd1;
                seg.last       = 1'b1;
                if (adv) begin
                    // chain straight into the next word when one is waiting
                    if (i_q_valid) begin
                        o_q_pop = 1'b1;
                        n_word  = i_q_word;
                        n_cnt   = CNT_W'(WORD_BITS - 1);
                        n_state = sdfs_pkg::SEG_CS_LO;
                    end else begin
                        n_state = sdfs_pkg::SEG_IDLE;
                    end
                end
            end
            default: begin
                n_state = sdfs_pkg::SEG_IDLE;
            end
        endcase

        if (adv && (r_state != sdfs_pkg::SEG_IDLE)) begin
            n_out_valid = 1'b1;
            n_out       = seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdfs_pkg::SEG_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_cnt  <= n_cnt;
        r_out  <= n_out;
    end

    assign o_seg_valid = r_out_valid;
    assign o_seg       = r_out;

    // final segment is the idle return with everything released
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> (r_out.cs_n && r_out.sclk && r_out.ldac_n
                                         && !r_out.mosi && (r_out.hold_ticks == 16'd1)))
        else $error("final segment levels wrong");

    // no segment has a zero hold time
    a_hold_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.hold_ticks != '0))
        else $error("zero hold time");

    // serial clock only drops while chip select is asserted
    a_sclk_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.sclk) |-> (!r_out.cs_n && r_out.ldac_n))
        else $error("sclk low outside frame");

    // a word is only taken from the queue at the start of a frame
    a_pop_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == sdfs_pkg::SEG_CS_LO))
        else $error("queue pop mid frame");

endmodule

@@ rtl/core/spi_dac_frame_sequencer_top.sv @@
// SPI DAC write sequencer. Each input transaction (channel select + 12-bit
// code) is turned into the pin waveform of one mode-3 write to a dual DAC,
// delivered as 2*WORD_BITS+7 output transactions (39 at WORD_BITS = 16), each
// giving the cs_n/sclk/mosi/ldac_n levels and how many clocks they are held.
// The command word is code | channel bits | 0x4000, sent MSB first; with a
// short word only its low WORD_BITS bits go out. The output port delivers one
// segment per clock while i_out_stall is low, and the pin sequencer that
// builds the segments sets the sustained throughput. A decode stage and a
// QUEUE_DEPTH-word queue sit ahead of the sequencer, so new writes are
// accepted while the previous one is still being played out; frames follow
// each other with no gap. Timing registers (APB, byte address 0:
// delay_ticks, 4: half_bit_ticks) are sampled as segments are built and
// should only be written while idle; a value of zero acts as one.
module spi_dac_frame_sequencer_top #(
    parameter int WORD_BITS   = sdfs_pkg::WORD_BITS,
    parameter int QUEUE_DEPTH = sdfs_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // request channel
    input  logic                            i_in_valid,
    input  sdfs_pkg::t_req                  i_in_data,
    output logic                            o_in_stall,

    // segment channel
    output logic                            o_out_valid,
    output sdfs_pkg::t_seg                  o_out_data,
    input  logic                            i_out_stall,

    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sdfs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [15:0]          r_delay;
    logic [7:0]           r_half;
    logic                 cfg_wr;
    logic                 cfg_idx;
    sdfs_pkg::t_timing    timing;

    logic                 push;
    logic [WORD_BITS-1:0] push_word;
    logic                 q_full;
    logic                 q_valid;
    logic [WORD_BITS-1:0] q_word;
    logic                 q_pop;

    // register index is the word address; low byte-offset bits unused
    assign pready  = 1'b1;
    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= sdfs_pkg::DELAY_RESET;
            r_half  <= sdfs_pkg::HALF_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                sdfs_pkg::REG_DELAY: r_delay <= pwdata[15:0];
                sdfs_pkg::REG_HALF:  r_half  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            sdfs_pkg::REG_DELAY: prdata = {16'b0, r_delay};
            sdfs_pkg::REG_HALF:  prdata = {24'b0, r_half};
            default:             prdata = '0;
        endcase
    end

    assign timing.delay_ticks    = r_delay;
    assign timing.half_bit_ticks = r_half;

    // decode: build the command word
    sdfs_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_word     (push_word),
        .i_full     (q_full)
    );

    // words waiting for the sequencer
    sdfs_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_word),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_word),
        .i_pop   (q_pop)
    );

    // pin sequencer: one segment per clock, unless stalled, into a registered output
    sdfs_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_timing    (timing),
        .i_q_valid   (q_valid),
        .i_q_word    (q_word),
        .o_q_pop     (q_pop),
        .o_seg_valid (o_out_valid),
        .o_seg       (o_out_data),
        .i_seg_stall (i_out_stall)
    );

endmodule

@@ bench/spi_dac_frame_sequencer_top_tb.sv @@
module spi_dac_frame_sequencer_top_tb;

    // Bound on the whole run in clock cycles. The slowest correct run is about
    // 360 writes x 39 segments, every segment stalled the longest, plus sender
    // gaps and drain pauses, and stays well below the bound.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Cycles to wait after the last segment before touching the registers or
    // ending the run.
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX = 10;

    // Selector value with no channel bits; behaves like FUNC_BOTH.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // APB byte addresses of the timing registers
    localparam logic [sdfs_pkg::CFG_ADDR_W-1:0] ADDR_DELAY = {sdfs_pkg::REG_DELAY, 2'b00};
    localparam logic [sdfs_pkg::CFG_ADDR_W-1:0] ADDR_HALF  = {sdfs_pkg::REG_HALF, 2'b00};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request channel
    logic           req_valid = 1'b0;
    sdfs_pkg::t_req req_data  = '0;
    logic           req_stall;

    // segment channel
    logic           seg_valid;
    sdfs_pkg::t_seg seg_data;
    logic           seg_stall = 1'b0;

    // configuration port
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [sdfs_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]                     pwdata  = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    // Local copy of the timing registers, updated as each APB write lands
    logic [15:0] delay_cfg = sdfs_pkg::DELAY_RESET;
    logic [7:0]  half_cfg  = sdfs_pkg::HALF_RESET;

    // Pin segments still owed by the DUT, oldest first
    sdfs_pkg::t_seg seg_expected[$];

    int  fail_count = 0;
    bit  idle_on    = 1'b1;  // random gaps on the sender and stalls on the receiver
    int  stall_left = 0;

    spi_dac_frame_sequencer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .i_in_data   (req_data),
        .o_in_stall  (req_stall),
        .o_out_valid (seg_valid),
        .o_out_data  (seg_data),
        .i_out_stall (seg_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Waveform predictor
    // ------------------------------------------------------------------

    function automatic void queue_segment(input logic cs_n, input logic sclk,
                                          input logic mosi, input logic ldac_n,
                                          input logic [15:0] hold, input logic last);
        sdfs_pkg::t_seg seg;
        seg.cs_n       = cs_n;
        seg.sclk       = sclk;
        seg.mosi       = mosi;
        seg.ldac_n     = ldac_n;
        seg.hold_ticks = hold;
        seg.last       = last;
        seg_expected.push_back(seg);
    endfunction

    // Builds the full pin sequence of one DAC write from the current timing
    // registers and appends it to seg_expected.
    function automatic void predict_dac_write(input sdfs_pkg::t_req req);
        logic [15:0] word;
        logic [15:0] d_hold;
        logic [15:0] h_hold;
        word = {4'b0, req.data_value & sdfs_pkg::SAMPLE_MASK};
        case (req.func)
            sdfs_pkg::FUNC_A: word = word | sdfs_pkg::CHAN_A_BITS;
            sdfs_pkg::FUNC_B: word = word | sdfs_pkg::CHAN_B_BITS;
            default:          word = word;  // both outputs, unused selector: no channel bits
        endcase
        word = word | sdfs_pkg::CMD_BIT;
        // zero timing values act as one
        d_hold = (delay_cfg == 16'd0) ? 16'd1 : delay_cfg;
        h_hold = (half_cfg == 8'd0) ? 16'd1 : {8'd0, half_cfg};

        // cs low, high, then low as setup before the first clock edge
        queue_segment(1'b0, 1'b1, 1'b0, 1'b1, d_hold, 1'b0);
        queue_segment(1'b1, 1'b1, 1'b0, 1'b1, d_hold, 1'b0);
        queue_segment(1'b0, 1'b1, 1'b0, 1'b1, h_hold, 1'b0);
        // mode 3, MSB first: low half then high half per bit
        for (int b = sdfs_pkg::WORD_BITS - 1; b >= 0; b--) begin
            queue_segment(1'b0, 1'b0, word[b & 15], 1'b1, h_hold, 1'b0);
            queue_segment(1'b0, 1'b1, word[b & 15], 1'b1, h_hold, 1'b0);
        end
        // cs hold and release, load strobe, return to idle
        queue_segment(1'b0, 1'b1, 1'b0, 1'b1, d_hold, 1'b0);
        queue_segment(1'b1, 1'b1, 1'b0, 1'b1, d_hold, 1'b0);
        queue_segment(1'b1, 1'b1, 1'b0, 1'b0, d_hold, 1'b0);
        queue_segment(1'b1, 1'b1, 1'b0, 1'b1, 16'd1, 1'b1);
    endfunction

    // Every accepted request transaction gets its waveform predicted at the
    // edge that accepts it. Registers only change while idle, so the copy in
    // delay_cfg/half_cfg is the one the DUT uses for this write.
    always @(posedge clk) begin
        if (rst_n && req_valid && !req_stall) begin
            predict_dac_write(req_data);
        end
    end

    // ------------------------------------------------------------------
    // Segment checker
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        sdfs_pkg::t_seg want;
        if (rst_n && seg_valid && !seg_stall) begin
            if (seg_expected.size() == 0) begin
                if (fail_count < REPORT_MAX) begin
                    $display({"unexpected segment: cs_n=%0b sclk=%0b mosi=%0b",
                              " ldac_n=%0b hold=%0d last=%0b"},
                             seg_data.cs_n, seg_data.sclk, seg_data.mosi,
                             seg_data.ldac_n, seg_data.hold_ticks, seg_data.last);
                end
                fail_count++;
            end else begin
                want = seg_expected.pop_front();
                if (seg_data.cs_n !== want.cs_n || seg_data.sclk !== want.sclk ||
                    seg_data.mosi !== want.mosi || seg_data.ldac_n !== want.ldac_n ||
                    seg_data.hold_ticks !== want.hold_ticks ||
                    seg_data.last !== want.last) begin
                    if (fail_count < REPORT_MAX) begin
                        $display({"segment mismatch: expected cs_n=%0b sclk=%0b",
                                  " mosi=%0b ldac_n=%0b hold=%0d last=%0b"},
                                 want.cs_n, want.sclk, want.mosi, want.ldac_n,
                                 want.hold_ticks, want.last);
                        $display({"                  actual   cs_n=%0b sclk=%0b",
                                  " mosi=%0b ldac_n=%0b hold=%0d last=%0b"},
                                 seg_data.cs_n, seg_data.sclk, seg_data.mosi,
                                 seg_data.ldac_n, seg_data.hold_ticks, seg_data.last);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Receiver back-pressure: random stall bursts while idle_on is set.
    // At most one nonblocking write to seg_stall per edge.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            seg_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end else begin
            seg_stall <= 1'b0;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("spi_dac_frame_sequencer_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Send one write request. Valid is left high after acceptance so that
    // back-to-back transactions never drop it; gaps and wait_drained lower it.
    task automatic send_write(input logic [1:0] func, input logic [11:0] code);
        sdfs_pkg::t_req req;
        req.func       = func;
        req.data_value = code;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    // Stop sending and wait for every owed segment, then let the pipe settle.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (seg_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup phase, access phase until pready, then back to idle.
    task automatic cfg_write(input logic [sdfs_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DELAY) begin
            delay_cfg = value[15:0];
        end else if (addr == ADDR_HALF) begin
            half_cfg = value[7:0];
        end
        @(posedge clk);
    endtask

    task automatic set_timing(input logic [15:0] d_ticks, input logic [7:0] h_ticks);
        wait_drained();
        // upper pwdata bits are don't-care; fill them to make sure they are dropped
        cfg_write(ADDR_DELAY, {16'($urandom), d_ticks});
        cfg_write(ADDR_HALF, {24'($urandom), h_ticks});
    endtask

    function automatic logic [15:0] pick_delay();
        case ($urandom_range(0, 4))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return 16'd0;     // acts as one
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [7:0] pick_half();
        case ($urandom_range(0, 4))
            0:       return 8'd1;
            1:       return 8'hFF;
            2:       return 8'd0;      // acts as one
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset timing values; every selector with all-zero and all-one codes,
    // plus alternating patterns on the two channels.
    task automatic test_selectors_and_codes();
        send_write(sdfs_pkg::FUNC_BOTH, 12'h000);
        send_write(sdfs_pkg::FUNC_BOTH, 12'hFFF);
        send_write(sdfs_pkg::FUNC_A,    12'h000);
        send_write(sdfs_pkg::FUNC_A,    12'hFFF);
        send_write(sdfs_pkg::FUNC_B,    12'h000);
        send_write(sdfs_pkg::FUNC_B,    12'hFFF);
        send_write(FUNC_UNUSED,         12'h000);
        send_write(FUNC_UNUSED,         12'hFFF);
        send_write(sdfs_pkg::FUNC_A,    12'hAAA);
        send_write(sdfs_pkg::FUNC_B,    12'h555);
    endtask

    // Minimum, maximum and zero timing values.
    task automatic test_timing_extremes();
        set_timing(16'd1, 8'd1);
        send_write(sdfs_pkg::FUNC_A, 12'h800);
        send_write(sdfs_pkg::FUNC_B, 12'h001);
        set_timing(16'hFFFF, 8'hFF);
        send_write(sdfs_pkg::FUNC_BOTH, 12'h7FF);
        send_write(FUNC_UNUSED, 12'h123);
        set_timing(16'd0, 8'd0);
        send_write(sdfs_pkg::FUNC_A, 12'hFFF);
        send_write(sdfs_pkg::FUNC_B, 12'h000);
        set_timing(sdfs_pkg::DELAY_RESET, sdfs_pkg::HALF_RESET);
        send_write(sdfs_pkg::FUNC_BOTH, 12'hC3C);
        send_write(sdfs_pkg::FUNC_A, 12'h3C3);
    endtask

    // Random requests over several timing settings. Midway through one phase
    // the sender holds off until every owed segment has come back.
    task automatic test_random_writes();
        for (int phase = 0; phase < 6; phase++) begin
            set_timing(pick_delay(), pick_half());
            for (int n = 0; n < 50; n++) begin
                if (phase == 2 && n == 25) begin
                    wait_drained();
                end
                send_write(2'($urandom_range(0, 3)), 12'($urandom));
            end
        end
    endtask

    // No gaps, no stalls: frames must follow each other at full rate.
    task automatic test_back_to_back();
        set_timing(pick_delay(), pick_half());
        idle_on = 1'b0;
        for (int n = 0; n < 40; n++) begin
            send_write(2'($urandom_range(0, 3)), 12'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_selectors_and_codes();
        test_timing_extremes();
        test_random_writes();
        test_back_to_back();
        wait_drained();

        // anything still owed is a missing segment
        fail_count += seg_expected.size();
        if (fail_count == 0) begin
            $display("spi_dac_frame_sequencer_top test passed");
        end else begin
            $display("spi_dac_frame_sequencer_top test failed");
        end
        $finish;
    end

endmodule
